### rtl/core/mpu_pkg.sv
// Shared types, register indexes and helper functions for the mask pixel unpack core.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package mpu_pkg;

    localparam int PIXEL_W    = 32;
    localparam int POS_W      = 5;
    localparam int SPAN_W     = 6;
    localparam int CHAN_W     = 8;
    localparam int SRC_BITS_W = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_CHAN   = 4;

    // Register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_MASK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_MASK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MASK  = 3'd4;

    // Reset values of the registers
    localparam logic [SRC_BITS_W-1:0] RST_SOURCE_BITS = 6'd32;
    localparam logic [PIXEL_W-1:0]    RST_RED_MASK    = 32'h0000_00ff;
    localparam logic [PIXEL_W-1:0]    RST_GREEN_MASK  = 32'h0000_ff00;
    localparam logic [PIXEL_W-1:0]    RST_BLUE_MASK   = 32'h00ff_0000;
    localparam logic [PIXEL_W-1:0]    RST_ALPHA_MASK  = 32'hff00_0000;

    localparam logic [SRC_BITS_W-1:0] MAX_MASK_BITS = 6'd32;

    localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;
    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hff;

    // Channel slots in per-channel arrays
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    typedef enum logic [2:0] {
        MODE_MASK,
        MODE_GRAY1,
        MODE_GRAY2,
        MODE_GRAY4,
        MODE_GRAY8,
        MODE_BAD
    } pix_mode_t;

    // Position of a channel inside the source pixel
    typedef struct packed {
        logic             present;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] msb;
    } chan_geom_t;

    // Extracted channel bits, left-aligned in 8 bits
    typedef struct packed {
        logic              present;
        logic [3:0]        span;
        logic [CHAN_W-1:0] bits;
    } chan_part_t;

    // Fill the low bits of a left-aligned value by repeating its top span bits
    function automatic logic [CHAN_W-1:0] replicate_bits(input logic [CHAN_W-1:0] value,
                                                         input logic [3:0] span);
        logic [CHAN_W-1:0] acc;
        logic [4:0]        have;
        acc  = value;
        have = {1'b0, span};
        for (int i = 0; i < 3; i++) begin
            if (have < 5'd8) begin
                acc  = acc | (acc >> have);
                have = have << 1;
            end
        end
        return acc;
    endfunction

endpackage

### rtl/core/mpu_if.sv
// Stream and configuration interfaces of the mask pixel unpack core.
// Depends on mpu_pkg for field widths.
`timescale 1ns / 1ps

interface mpu_pixel_if;
    import mpu_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface mpu_rgba_if;
    import mpu_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
    logic              unsupported;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, output unsupported, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input alpha_out, input unsupported, output ready);
endinterface

interface mpu_cfg_if;
    import mpu_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PIXEL_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/mpu_mask_scan.sv
// Mask scanner: finds the lowest and highest set bit of one channel mask.
// Depends on mpu_pkg.
`timescale 1ns / 1ps

module mpu_mask_scan (
    input  logic [mpu_pkg::PIXEL_W-1:0] mask,
    output mpu_pkg::chan_geom_t         geom
);
    import mpu_pkg::*;

    logic [POS_W-1:0] low_bit;
    logic [POS_W-1:0] high_bit;

    always_comb
    begin
        low_bit  = '0;
        high_bit = '0;
        for (int i = PIXEL_W - 1; i >= 0; i--) begin
            if (mask[i]) begin
                low_bit = POS_W'(i);
            end
        end
        for (int i = 0; i < PIXEL_W; i++) begin
            if (mask[i]) begin
                high_bit = POS_W'(i);
            end
        end
    end

    assign geom.present = |mask;
    assign geom.pos     = low_bit;
    assign geom.msb     = high_bit;

endmodule

### rtl/core/mpu_chan_align.sv
// Channel extractor: pulls a channel's bits out of the pixel and left-aligns them.
// Depends on mpu_pkg.
`timescale 1ns / 1ps

module mpu_chan_align (
    input  logic [mpu_pkg::PIXEL_W-1:0] pixel,
    input  mpu_pkg::chan_geom_t         geom,
    output mpu_pkg::chan_part_t         part
);
    import mpu_pkg::*;

    logic [SPAN_W-1:0]  span;
    logic               wide;
    logic [POS_W-1:0]   shift;
    logic [PIXEL_W-1:0] shifted;
    logic [CHAN_W-1:0]  low8;

    always_comb
    begin
        span    = SPAN_W'(geom.msb) - SPAN_W'(geom.pos) + SPAN_W'(1);
        wide    = span > SPAN_W'(8);
        // wide channels keep their top eight bits
        shift   = wide ? (geom.msb - POS_W'(7)) : geom.pos;
        shifted = pixel >> shift;
        low8    = shifted[CHAN_W-1:0];

        part.present = geom.present;
        if (wide) begin
            part.span = 4'd8;
            part.bits = low8;
        end else begin
            part.span = span[3:0];
            // bits above the span fall off the top
            part.bits = low8 << (4'd8 - span[3:0]);
        end
    end

endmodule

### rtl/core/mpu_chan_fill.sv
// Channel filler: replicates a narrow channel to 8 bits or drives the absent value.
// Depends on mpu_pkg.
`timescale 1ns / 1ps

module mpu_chan_fill (
    input  mpu_pkg::chan_part_t        part,
    input  logic [mpu_pkg::CHAN_W-1:0] absent_value,
    output logic [mpu_pkg::CHAN_W-1:0] value
);
    import mpu_pkg::*;

    assign value = part.present ? replicate_bits(part.bits, part.span) : absent_value;

endmodule

### rtl/core/mask_pixel_unpack_rgba_core.sv
// Top level of the mask pixel unpack core: configuration registers and the 3-stage pipeline.
// Depends on mpu_pkg, mpu_if, mpu_mask_scan, mpu_chan_align and mpu_chan_fill.
`timescale 1ns / 1ps

// Unpacks one raw pixel per clock, unless dst stalls, into 8-bit red, green, blue and
// alpha. Throughput is one pixel per cycle while dst is ready; the register stages are
// mask scan, channel extract, then replicate into the output register. With a nonzero red
// mask each channel is located by its mask; otherwise the low source_bits bits are
// treated as 1, 2, 4 or 8 bit gray, and any other setup flags unsupported with zeros.
// Registers are written over the cfg channel, which is always ready; write them only
// while no pixel is in flight.
module mask_pixel_unpack_rgba_core (
    input  logic          clk,
    input  logic          rst_n,
    mpu_cfg_if.sink       cfg,
    mpu_pixel_if.sink     src,
    mpu_rgba_if.source    dst
);
    import mpu_pkg::*;

    // Configuration registers
    logic [SRC_BITS_W-1:0] source_bits_reg;
    logic [PIXEL_W-1:0]    red_mask_reg;
    logic [PIXEL_W-1:0]    green_mask_reg;
    logic [PIXEL_W-1:0]    blue_mask_reg;
    logic [PIXEL_W-1:0]    alpha_mask_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            source_bits_reg <= RST_SOURCE_BITS;
            red_mask_reg    <= RST_RED_MASK;
            green_mask_reg  <= RST_GREEN_MASK;
            blue_mask_reg   <= RST_BLUE_MASK;
            alpha_mask_reg  <= RST_ALPHA_MASK;
        end else if (cfg.valid && cfg.ready) begin
            unique case (cfg.index)
                REG_SOURCE_BITS: source_bits_reg <= cfg.data[SRC_BITS_W-1:0];
                REG_RED_MASK:    red_mask_reg    <= cfg.data;
                REG_GREEN_MASK:  green_mask_reg  <= cfg.data;
                REG_BLUE_MASK:   blue_mask_reg   <= cfg.data;
                REG_ALPHA_MASK:  alpha_mask_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage loads when it is empty or its contents move on
    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic en1, en2, en3;

    assign en3 = !v3_reg || dst.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign src.ready = en1;

    always_comb
    begin
        v1_next = en1 ? src.valid : v1_reg;
        v2_next = en2 ? v1_reg : v2_reg;
        v3_next = en3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Stage 1: mask scan and mode decode
    logic [PIXEL_W-1:0] mask_sel [NUM_CHAN];
    chan_geom_t         geom_comb [NUM_CHAN];
    pix_mode_t          mode_comb;

    assign mask_sel[CH_RED]   = red_mask_reg;
    assign mask_sel[CH_GREEN] = green_mask_reg;
    assign mask_sel[CH_BLUE]  = blue_mask_reg;
    assign mask_sel[CH_ALPHA] = alpha_mask_reg;

    always_comb
    begin
        if (red_mask_reg != '0) begin
            mode_comb = (source_bits_reg <= MAX_MASK_BITS) ? MODE_MASK : MODE_BAD;
        end else begin
            unique case (source_bits_reg)
                6'd1:    mode_comb = MODE_GRAY1;
                6'd2:    mode_comb = MODE_GRAY2;
                6'd4:    mode_comb = MODE_GRAY4;
                6'd8:    mode_comb = MODE_GRAY8;
                default: mode_comb = MODE_BAD;
            endcase
        end
    end

    logic [PIXEL_W-1:0] pix1_reg;
    chan_geom_t         geom1_reg [NUM_CHAN];
    pix_mode_t          mode1_reg;

    // Stage 2: channel extract and gray expand
    chan_part_t         part_comb [NUM_CHAN];
    logic [CHAN_W-1:0]  gray_comb;

    chan_part_t         part2_reg [NUM_CHAN];
    logic [CHAN_W-1:0]  gray2_reg;
    pix_mode_t          mode2_reg;

    // Stage 3: replicate and select
    logic [CHAN_W-1:0]  fill_comb [NUM_CHAN];
    logic [CHAN_W-1:0]  absent_sel [NUM_CHAN];

    assign absent_sel[CH_RED]   = CHAN_ZERO;
    assign absent_sel[CH_GREEN] = CHAN_ZERO;
    assign absent_sel[CH_BLUE]  = CHAN_ZERO;
    assign absent_sel[CH_ALPHA] = CHAN_FULL;

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
        mpu_mask_scan u_scan (
            .mask (mask_sel[c]),
            .geom (geom_comb[c])
        );

        mpu_chan_align u_align (
            .pixel (pix1_reg),
            .geom  (geom1_reg[c]),
            .part  (part_comb[c])
        );

        mpu_chan_fill u_fill (
            .part         (part2_reg[c]),
            .absent_value (absent_sel[c]),
            .value        (fill_comb[c])
        );
    end

    always_comb
    begin
        case (mode1_reg)
            MODE_GRAY1: gray_comb = pix1_reg[0] ? CHAN_FULL : CHAN_ZERO;
            MODE_GRAY2: gray_comb = {4{pix1_reg[1:0]}};
            MODE_GRAY4: gray_comb = {2{pix1_reg[3:0]}};
            default:    gray_comb = pix1_reg[CHAN_W-1:0];
        endcase
    end

    logic [CHAN_W-1:0] red_next, green_next, blue_next, alpha_next;
    logic              bad_next;

    always_comb
    begin
        red_next   = CHAN_ZERO;
        green_next = CHAN_ZERO;
        blue_next  = CHAN_ZERO;
        alpha_next = CHAN_ZERO;
        bad_next   = 1'b0;
        unique case (mode2_reg)
            MODE_MASK:
            begin
                red_next   = fill_comb[CH_RED];
                green_next = fill_comb[CH_GREEN];
                blue_next  = fill_comb[CH_BLUE];
                alpha_next = fill_comb[CH_ALPHA];
            end
            MODE_GRAY1, MODE_GRAY2, MODE_GRAY4, MODE_GRAY8:
            begin
                red_next   = gray2_reg;
                green_next = gray2_reg;
                blue_next  = gray2_reg;
                alpha_next = CHAN_FULL;
            end
            default:
            begin
                bad_next = 1'b1;
            end
        endcase
    end

    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic              bad_reg;

    // Payload registers: load on a transfer into each stage, hold otherwise
    always_ff @(posedge clk)
    begin
        if (en1 && src.valid) begin
            pix1_reg  <= src.pixel_in;
            geom1_reg <= geom_comb;
            mode1_reg <= mode_comb;
        end
        if (en2 && v1_reg) begin
            part2_reg <= part_comb;
            gray2_reg <= gray_comb;
            mode2_reg <= mode1_reg;
        end
        if (en3 && v2_reg) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= alpha_next;
            bad_reg   <= bad_next;
        end
    end

    assign dst.valid       = v3_reg;
    assign dst.red_out     = red_reg;
    assign dst.green_out   = green_reg;
    assign dst.blue_out    = blue_reg;
    assign dst.alpha_out   = alpha_reg;
    assign dst.unsupported = bad_reg;

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dst.valid && dst.unsupported) |->
        (dst.red_out == CHAN_ZERO && dst.green_out == CHAN_ZERO &&
         dst.blue_out == CHAN_ZERO && dst.alpha_out == CHAN_ZERO))
        else $error("unsupported result carries nonzero channels");

    a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (dst.valid && !dst.unsupported &&
         (red_mask_reg == '0 || alpha_mask_reg == '0)) |->
        (dst.alpha_out == CHAN_FULL))
        else $error("alpha not opaque with no alpha channel");

    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !en3) |=> v3_reg && v2_reg)
        else $error("stalled pipeline lost an item");
`endif

endmodule
